// File: rtl/sorted_index_join_probe_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted-index join probe unit
// Shared concurrent assertion forms, each with a label, a clock and a
// disable condition.
// ----------------------------------------------------------------------------
`ifndef SORTED_INDEX_JOIN_PROBE_UNIT_ASSERT_SVH
`define SORTED_INDEX_JOIN_PROBE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SIJ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication.
`define SIJ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/sij_pkg.sv
// ----------------------------------------------------------------------------
// sij_pkg
// Field widths, command codes and the work item type shared by the
// front end, the work queue and the back end of the join probe unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sij_pkg;

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 10;
   localparam int DATA_W      = 32;
   localparam int REF_W       = 10;
   localparam int COUNT_W     = 11;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 128;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_INDEX = 2'd0,
      CMD_LOAD_RIGHT = 2'd1,
      CMD_PROBE      = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                   op;
      logic [SLOT_W-1:0]         slot;
      logic signed [DATA_W-1:0]  key;
      logic signed [DATA_W-1:0]  value;
      logic [REF_W-1:0]          row;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } work_chan_type;

endpackage

`default_nettype wire

// File: rtl/sij_front.sv
// ----------------------------------------------------------------------------
// sij_front
// Accepts requests, drops unused codes and out-of-range loads, folds the
// row reference into the table depth and offers the work item to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sij_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sij_pkg::CMD_W-1:0]         req_tuser,
   input  wire logic [sij_pkg::REQ_DATA_W-1:0]    req_tdata,
   output sij_pkg::work_chan_type                 push,
   input  wire logic                              push_ready
);
   import sij_pkg::*;

   function automatic logic [REF_W-1:0] reduce_row(input logic [REF_W-1:0] r);
      logic [REF_W-1:0] acc;
      longint           lim;
      acc = r;
      for (int k = REF_W - 1; k >= 0; k--) begin
         lim = longint'(TABLE_DEPTH) << k;
         if (lim < (longint'(1) << REF_W) && longint'(acc) >= lim) begin
            acc = acc - REF_W'(lim);
         end
      end
      return acc;
   endfunction

   cmd_type          cmd;
   logic [SLOT_W-1:0] f_slot;
   logic             slot_ok;
   logic             keep;
   work_chan_type    hold_ff, hold_in;

   assign cmd     = cmd_type'(req_tuser);
   assign f_slot  = req_tdata[SLOT_W-1:0];
   assign slot_ok = int'(f_slot) < TABLE_DEPTH;

   assign req_tready = !hold_ff.valid || push_ready;
   assign push       = hold_ff;

   always_comb begin
      unique case (cmd) inside
         CMD_LOAD_INDEX, CMD_LOAD_RIGHT: begin
            keep = slot_ok;
         end
         CMD_PROBE: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      hold_in = hold_ff;
      if (hold_ff.valid && push_ready) begin
         hold_in.valid = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         hold_in.valid      = keep;
         hold_in.item.op    = cmd;
         hold_in.item.slot  = f_slot;
         hold_in.item.key   = req_tdata[SLOT_W +: DATA_W];
         hold_in.item.value = req_tdata[SLOT_W + DATA_W +: DATA_W];
         hold_in.item.row   = reduce_row(req_tdata[SLOT_W + 2*DATA_W +: REF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sij_queue.sv
// ----------------------------------------------------------------------------
// sij_queue
// Short first-in first-out queue of work items between the front end and
// the back end, so that either side may stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sij_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sij_pkg::work_chan_type push,
   output logic                       push_ready,
   output sij_pkg::work_chan_type     pop,
   input  wire logic                  pop_ready
);
   import sij_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);

   work_type           entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != (QAW+1)'(QUEUE_DEPTH);
   assign pop.valid  = count_ff != '0;
   assign pop.item   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sij_back.sv
// ----------------------------------------------------------------------------
// sij_back
// Holds the sorted index and the right tuples, carries out loads, runs the
// binary search and the two walks of a probe, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sij_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MATCH_CAP   = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [sij_pkg::COUNT_W-1:0]    table_count,
   input  wire sij_pkg::work_chan_type         pop,
   output logic                                pop_ready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [sij_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   output logic [0:0]                          rsp_tuser
);
   import sij_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = NW + 1;
   localparam int FW = $clog2(MATCH_CAP + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [REF_W-1:0]         row;
   } index_entry_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } right_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CMP,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   index_entry_type idx_mem   [TABLE_DEPTH];
   right_entry_type right_mem [TABLE_DEPTH];
   index_entry_type idx_rd_ff;
   right_entry_type right_rd_ff;

   logic            idx_we;
   logic            right_we;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   idx_raddr;

   state_type                 state_ff, state_in;
   state_type                 cont_ff, cont_in;
   logic signed [DATA_W-1:0]  pkey_ff, pkey_in;
   logic signed [DATA_W-1:0]  pval_ff, pval_in;
   logic signed [SW-1:0]      lo_ff, lo_in;
   logic signed [SW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic [AW-1:0]             start_ff, start_in;
   logic [NW-1:0]             x_ff, x_in;
   logic                      up_ff, up_in;
   logic [FW-1:0]             found_ff, found_in;
   logic [AW-1:0]             pend_ff, pend_in;
   logic [AW-1:0]             emit_row_ff, emit_row_in;
   logic                      emit_last_ff, emit_last_in;
   logic                      emit_trunc_ff, emit_trunc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_trunc_ff, rsp_trunc_in;

   logic [NW-1:0]             n_live;
   logic [SW:0]               mid_sum;
   logic [AW-1:0]             mid_calc;
   logic signed [SW-1:0]      mid_s;
   logic signed [SW-1:0]      lo_next;
   logic signed [SW-1:0]      hi_next;
   logic                      less;
   logic                      match;
   logic [NW-1:0]             after_start;

   assign n_live      = (int'(table_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH)
                                                          : NW'(table_count);
   assign mid_sum     = {lo_ff[SW-1], lo_ff} + {hi_ff[SW-1], hi_ff};
   assign mid_calc    = mid_sum[AW:1];
   assign mid_s       = $signed(SW'(mid_ff));
   assign less        = $signed(pval_ff) < $signed(idx_rd_ff.value);
   assign lo_next     = less ? lo_ff : mid_s + SW'(1);
   assign hi_next     = less ? mid_s - SW'(1) : hi_ff;
   assign match       = idx_rd_ff.value == pval_ff;
   assign after_start = NW'(start_ff) + NW'(1);

   assign pop_ready = state_ff == ST_IDLE;
   assign idx_we    = pop_ready && pop.valid && pop.item.op == CMD_LOAD_INDEX;
   assign right_we  = pop_ready && pop.valid && pop.item.op == CMD_LOAD_RIGHT;
   assign wr_addr   = AW'(pop.item.slot);
   assign idx_raddr = (state_ff == ST_ADDR) ? mid_calc : x_ff[AW-1:0];

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_trunc_ff;

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[wr_addr] <= '{value: pop.item.value, row: pop.item.row};
      end
      if (right_we) begin
         right_mem[wr_addr] <= '{key: pop.item.key, value: pop.item.value};
      end
      idx_rd_ff   <= idx_mem[idx_raddr];
      right_rd_ff <= right_mem[emit_row_ff];
   end

   always_comb begin
      state_in      = state_ff;
      cont_in       = cont_ff;
      pkey_in       = pkey_ff;
      pval_in       = pval_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      start_in      = start_ff;
      x_in          = x_ff;
      up_in         = up_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      emit_row_in   = emit_row_ff;
      emit_last_in  = emit_last_ff;
      emit_trunc_in = emit_trunc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_trunc_in  = rsp_trunc_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop.valid && pop.item.op == CMD_PROBE) begin
               pkey_in = pop.item.key;
               pval_in = pop.item.value;
               if (n_live != '0) begin
                  lo_in    = '0;
                  hi_in    = $signed(SW'(n_live) - SW'(1));
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            mid_in   = mid_calc;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (lo_next <= hi_next && !match) begin
               state_in = ST_ADDR;
            end else begin
               start_in = mid_ff;
               x_in     = NW'(mid_ff);
               up_in    = 1'b0;
               found_in = '0;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (up_ff && x_ff >= n_live) begin
               if (found_ff != '0) begin
                  emit_row_in   = pend_ff;
                  emit_last_in  = 1'b1;
                  emit_trunc_in = 1'b0;
                  cont_in       = ST_IDLE;
                  state_in      = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (match && found_ff == FW'(MATCH_CAP)) begin
               emit_row_in   = pend_ff;
               emit_last_in  = 1'b1;
               emit_trunc_in = 1'b1;
               cont_in       = ST_IDLE;
               state_in      = ST_EMIT_RD;
            end else if (match) begin
               found_in = found_ff + FW'(1);
               pend_in  = AW'(idx_rd_ff.row);
               if (up_ff) begin
                  x_in = x_ff + NW'(1);
               end else if (x_ff == '0) begin
                  up_in = 1'b1;
                  x_in  = after_start;
               end else begin
                  x_in = x_ff - NW'(1);
               end
               if (found_ff != '0) begin
                  emit_row_in   = pend_ff;
                  emit_last_in  = 1'b0;
                  emit_trunc_in = 1'b0;
                  cont_in       = ST_WALK_RD;
                  state_in      = ST_EMIT_RD;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end else if (!up_ff) begin
               up_in    = 1'b1;
               x_in     = after_start;
               state_in = ST_WALK_RD;
            end else if (found_ff != '0) begin
               emit_row_in   = pend_ff;
               emit_last_in  = 1'b1;
               emit_trunc_in = 1'b0;
               cont_in       = ST_IDLE;
               state_in      = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {right_rd_ff.value, right_rd_ff.key, pval_ff, pkey_ff};
               rsp_last_in  = emit_last_ff;
               rsp_trunc_in = emit_trunc_ff;
               state_in     = cont_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cont_ff      <= ST_IDLE;
         up_ff        <= 1'b0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_trunc_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cont_ff       <= cont_in;
         pkey_ff       <= pkey_in;
         pval_ff       <= pval_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         mid_ff        <= mid_in;
         start_ff      <= start_in;
         x_ff          <= x_in;
         up_ff         <= up_in;
         found_ff      <= found_in;
         pend_ff       <= pend_in;
         emit_row_ff   <= emit_row_in;
         emit_last_ff  <= emit_last_in;
         emit_trunc_ff <= emit_trunc_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_trunc_ff  <= rsp_trunc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sorted_index_join_probe_unit.sv
// ----------------------------------------------------------------------------
// sorted_index_join_probe_unit
// Index nested-loop join probe: loads a sorted index and right tuples, then
// answers probe requests with the joined pairs found by binary search.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream; tuser carries the command (load index
// entry, load right tuple, probe). Loads produce nothing; a probe produces
// zero or more joined pairs on the rsp_ stream, the final one with tlast set
// and tuser set as well when the match cap cut the run short.
// csr_we writes the number of valid index entries; write it only while idle.
// A request passes a registered front stage and a four-entry queue, so the
// front keeps taking requests while the back end is busy.
// A load is written while the back end is idle. A probe runs binary search
// steps (memory read, then compare), at most about log2(entries)+1 steps,
// then a read and a check per index entry inspected in the walks and a read
// and an output step per pair emitted; the single-port index read sets this.
// Reset empties the front stage, the queue and the result register and
// clears the entry count; the stores need no clearing and take no time.
// When the receiver stalls, the result register holds and the back end
// waits; the queue then fills and req_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_index_join_probe_unit_assert.svh"

module sorted_index_join_probe_unit #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MATCH_CAP   = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // tuser: cmd [1:0]
   // tdata: slot [9:0], tuple_key [41:10], tuple_value [73:42], row_ref [83:74]
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [sij_pkg::CMD_W-1:0]      req_tuser,
   input  wire logic [sij_pkg::REQ_DATA_W-1:0] req_tdata,
   // tdata: left_key [31:0], left_value [63:32], right_key [95:64],
   //        right_value [127:96]
   // tuser: truncated [0]
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [sij_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   output logic [0:0]                          rsp_tuser,
   input  wire logic                           csr_we,
   input  wire logic [sij_pkg::COUNT_W-1:0]    csr_wdata
);
   import sij_pkg::*;

   logic [COUNT_W-1:0] table_count_ff, table_count_in;
   work_chan_type      push;
   logic               push_ready;
   work_chan_type      pop;
   logic               pop_ready;

   assign table_count_in = csr_we ? csr_wdata : table_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_count_ff <= '0;
      end else begin
         table_count_ff <= table_count_in;
      end
   end

   sij_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_ready (push_ready)
   );

   sij_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   sij_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MATCH_CAP   (MATCH_CAP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .table_count (table_count_ff),
      .pop         (pop),
      .pop_ready   (pop_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   `SIJ_ASSERT_IMPLY(a_trunc_only_on_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `SIJ_ASSERT_IMPLY(a_quiet_after_reset, clock, 1'b0, $past(reset), !rsp_tvalid)
   `SIJ_ASSERT_NEXT(a_queue_offer_held, clock, reset, push.valid && !push_ready, push.valid && $stable(push.item))

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the sorted-index join probe unit
// Loads index entries and right tuples, sets the entry count, and checks
// every joined pair against a predictor kept inside the testbench. Covers the
// empty index, misses, runs that reach the match cap, a full table, counts
// above the table depth, and random small tables with random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import sij_pkg::*;

   localparam int          TABLE_DEPTH   = 1024;
   localparam int          MATCH_CAP     = 64;
   localparam int          SETTLE_CYCLES = 300;
   localparam int          RANDOM_ITEMS  = 110;
   localparam int          IDLE_PERCENT  = 17;
   localparam int          MAX_REPORTS   = 10;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam int          INT_MIN       = 32'sh8000_0000;
   localparam int          INT_MAX       = 32'sh7fff_ffff;

   typedef struct packed {
      logic [DATA_W-1:0] left_key;
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_key;
      logic [DATA_W-1:0] right_value;
      logic              last;
      logic              truncated;
   } join_pair_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [0:0]            rsp_tuser;
   logic                  csr_we;
   logic [COUNT_W-1:0]    csr_wdata;

   // Predictor state.
   int                    index_value_mem [TABLE_DEPTH];
   logic [REF_W-1:0]      index_row_mem   [TABLE_DEPTH];
   logic [DATA_W-1:0]     right_key_mem   [TABLE_DEPTH];
   logic [DATA_W-1:0]     right_value_mem [TABLE_DEPTH];
   int unsigned           entry_count;
   int                    loaded_rows [$];

   join_pair_t            pairs_due [$];

   bit                    steady;
   int                    rsp_hold_cycles;
   int                    mismatch_count;
   int                    probe_count;
   int                    load_count;
   int                    pair_count;
   int                    cut_count;
   int                    count_writes;

   sorted_index_join_probe_unit #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MATCH_CAP  (MATCH_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Walks the index exactly as the block does and queues the joined pairs.
   function automatic void predict_join(logic [DATA_W-1:0] key, int value);
      int lo;
      int hi;
      int mid;
      int x;
      int live;
      int hits [$];
      bit cut;
      int emit;
      int row;
      join_pair_t pair;
      live = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      if (live == 0)
         return;
      lo = 0;
      hi = live - 1;
      do begin
         mid = (lo + hi) / 2;
         if (value < index_value_mem[mid])
            hi = mid - 1;
         else
            lo = mid + 1;
      end while (lo <= hi && value != index_value_mem[mid]);
      x = mid;
      while (hits.size() <= MATCH_CAP && index_value_mem[x] == value) begin
         hits.push_back(x);
         if (x == 0)
            break;
         x--;
      end
      x = mid + 1;
      while (hits.size() <= MATCH_CAP && x < live && index_value_mem[x] == value) begin
         hits.push_back(x);
         x++;
      end
      cut = hits.size() > MATCH_CAP;
      emit = cut ? MATCH_CAP : hits.size();
      for (int k = 0; k < emit; k++) begin
         row = index_row_mem[hits[k]] % TABLE_DEPTH;
         pair.left_key = key;
         pair.left_value = value;
         pair.right_key = right_key_mem[row];
         pair.right_value = right_value_mem[row];
         pair.last = (k == emit - 1);
         pair.truncated = (k == emit - 1) && cut;
         pairs_due.push_back(pair);
      end
   endfunction

   function automatic void apply_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                         logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                                         logic [REF_W-1:0] row);
      if (cmd == CMD_LOAD_INDEX) begin
         index_value_mem[slot] = value;
         index_row_mem[slot] = row;
         load_count++;
      end else if (cmd == CMD_LOAD_RIGHT) begin
         right_key_mem[slot] = key;
         right_value_mem[slot] = value;
         loaded_rows.push_back(slot);
         load_count++;
      end else if (cmd == CMD_PROBE) begin
         predict_join(key, value);
         probe_count++;
      end
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                               input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] value,
                               input logic [REF_W-1:0] row);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{(REQ_DATA_W - 84){1'b0}}, row, value, key, slot};
      do
         @(posedge clock);
      while (!req_tready);
      apply_request(cmd, slot, key, value, row);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pairs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int unsigned count);
      csr_we <= 1'b1;
      csr_wdata <= count[COUNT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      entry_count = count;
      count_writes++;
   endtask

   function automatic logic [REF_W-1:0] pick_row();
      return loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
   endfunction

   // Receiver: random stalls, always ready in steady phases, or a long counted hold when one is asked for.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic void report_mismatch(string what, join_pair_t want, join_pair_t got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch in %s: expected %h/%h/%h/%h last %b cut %b, got %h/%h/%h/%h last %b cut %b",
                  $realtime, what, want.left_key, want.left_value, want.right_key,
                  want.right_value, want.last, want.truncated, got.left_key, got.left_value,
                  got.right_key, got.right_value, got.last, got.truncated);
   endfunction

   always @(posedge clock) begin : check_pairs
      join_pair_t got;
      join_pair_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_key = rsp_tdata[31:0];
         got.left_value = rsp_tdata[63:32];
         got.right_key = rsp_tdata[95:64];
         got.right_value = rsp_tdata[127:96];
         got.last = rsp_tlast;
         got.truncated = rsp_tuser[0];
         if (pairs_due.size() == 0) begin
            report_mismatch("unexpected pair", '0, got);
         end else begin
            want = pairs_due.pop_front();
            pair_count++;
            if (want.truncated)
               cut_count++;
            if (got.left_key !== want.left_key)
               report_mismatch("left_key", want, got);
            if (got.left_value !== want.left_value)
               report_mismatch("left_value", want, got);
            if (got.right_key !== want.right_key)
               report_mismatch("right_key", want, got);
            if (got.right_value !== want.right_value)
               report_mismatch("right_value", want, got);
            if (got.last !== want.last)
               report_mismatch("last", want, got);
            if (got.truncated !== want.truncated)
               report_mismatch("truncated", want, got);
         end
      end
   end

   task automatic test_empty_index();
      send_request(CMD_PROBE, '0, INT_MIN, INT_MIN, '0);
      send_request(CMD_PROBE, '1, INT_MAX, 0, '1);
      send_request(CMD_UNUSED, '1, '1, '1, '1);
      wait_idle();
   endtask

   task automatic test_small_table();
      send_request(CMD_LOAD_RIGHT, 10'd0, INT_MIN, INT_MAX, '0);
      send_request(CMD_LOAD_RIGHT, 10'd1023, INT_MAX, INT_MIN, '0);
      send_request(CMD_LOAD_INDEX, 10'd0, '0, INT_MIN, 10'd1023);
      send_request(CMD_LOAD_INDEX, 10'd1, '0, 0, 10'd0);
      send_request(CMD_LOAD_INDEX, 10'd2, '0, 0, 10'd1023);
      send_request(CMD_LOAD_INDEX, 10'd3, '1, INT_MAX, 10'd0);
      wait_idle();
      write_entry_count(4);
      send_request(CMD_PROBE, '0, INT_MIN, INT_MIN, '0);
      send_request(CMD_PROBE, '0, INT_MAX, 0, '0);
      send_request(CMD_PROBE, '0, 0, INT_MAX, '0);
      send_request(CMD_PROBE, '0, -1, 5, '0);
      wait_idle();
      write_entry_count(1);
      send_request(CMD_PROBE, '0, 7, INT_MIN, '0);
      send_request(CMD_PROBE, '0, 8, 0, '0);
      wait_idle();
   endtask

   // Fills all 1024 slots: a run longer than the cap, a run exactly at the
   // cap, pairs of equal values, and the largest value in the top slot.
   function automatic int full_table_value(int slot);
      if (slot < 70)
         return INT_MIN;
      if (slot < 134)
         return -5;
      if (slot < TABLE_DEPTH - 1)
         return ((slot - 134) / 2) * 7;
      return INT_MAX;
   endfunction

   task automatic test_full_table();
      int probes [$];
      repeat (30)
         send_request(CMD_LOAD_RIGHT, $urandom_range(0, 1023), $urandom, $urandom, $urandom);
      for (int s = 0; s < TABLE_DEPTH; s++)
         send_request(CMD_LOAD_INDEX, s, $urandom, full_table_value(s), pick_row());
      wait_idle();
      probes = '{INT_MIN, -5, -6, 0, 70, 71, 3101, 3108, 3109, INT_MAX};
      write_entry_count(TABLE_DEPTH);
      foreach (probes[i])
         send_request(CMD_PROBE, $urandom, $urandom, probes[i], $urandom);
      wait_idle();
      write_entry_count(2047);
      send_request(CMD_PROBE, $urandom, $urandom, INT_MIN, $urandom);
      send_request(CMD_PROBE, $urandom, $urandom, INT_MAX, $urandom);
      wait_idle();
      write_entry_count(1022);
      send_request(CMD_PROBE, $urandom, $urandom, 3101, $urandom);
      send_request(CMD_PROBE, $urandom, $urandom, INT_MAX, $urandom);
      wait_idle();
   endtask

   task automatic test_back_pressure();
      write_entry_count(TABLE_DEPTH);
      rsp_hold_cycles = 600;
      for (int i = 0; i < 12; i++)
         send_request(CMD_PROBE, $urandom, $urandom, (i % 3 == 0) ? 0 : -5, $urandom);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int sent;
      int choice;
      int unsigned count;
      int fill;
      int live;
      int value;
      int pool [$];
      int values [$];
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         choice = $urandom_range(0, 9);
         if (choice < 6)
            count = $urandom_range(1, 12);
         else if (choice == 6)
            count = 0;
         else if (choice == 7)
            count = TABLE_DEPTH;
         else if (choice == 8)
            count = 2047;
         else
            count = $urandom_range(13, 2046);
         fill = (count >= 1 && count <= 12) ? int'(count) : $urandom_range(1, 12);
         repeat ($urandom_range(0, 3)) begin
            send_request(CMD_LOAD_RIGHT, $urandom_range(0, 1023), $urandom, $urandom, $urandom);
            sent++;
         end
         pool.delete();
         values.delete();
         repeat ($urandom_range(1, 4))
            pool.push_back(($urandom_range(0, 7) == 0) ? INT_MAX : int'($urandom));
         if ($urandom_range(0, 7) == 0)
            pool.push_back(INT_MIN);
         repeat (fill)
            values.push_back(pool[$urandom_range(0, pool.size() - 1)]);
         if ($urandom_range(0, 9) != 0)
            values.sort();
         foreach (values[i]) begin
            send_request(CMD_LOAD_INDEX, i, $urandom, values[i], pick_row());
            sent++;
         end
         wait_idle();
         write_entry_count(count);
         live = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end else begin
               if (live > 0 && $urandom_range(0, 3) != 0)
                  value = index_value_mem[$urandom_range(0, live - 1)];
               else
                  value = $urandom;
               if ($urandom_range(0, 9) == 0)
                  value++;
               send_request(CMD_PROBE, $urandom, $urandom, value, $urandom);
               sent++;
            end
         end
         wait_idle();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      steady = 1'b0;
      rsp_hold_cycles = 0;
      entry_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_index();
      test_small_table();
      test_full_table();
      test_back_pressure();
      test_random_phases();
      wait_idle();
      $display("Sent %0d probes and %0d loads; checked %0d joined pairs, %0d of them cut at the cap.",
               probe_count, load_count, pair_count, cut_count);
      $display("Entry count written %0d times, from empty up to beyond the table depth.",
               count_writes);
      if (mismatch_count == 0 && pairs_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sij_pkg.sv
rtl/sij_front.sv
rtl/sij_queue.sv
rtl/sij_back.sv
rtl/sorted_index_join_probe_unit.sv
sim/testbench.sv
